/* rtl/qts_pkg.sv */
// Shared constants, types and register indexes of the quintic trajectory sampler.
package qts_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned SBits       = 30;
  localparam int unsigned SW          = SBits + 1;
  localparam int unsigned MagW        = 34;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgAddrW    = 3;

  typedef enum logic [CfgAddrW-1:0] {
    RegFromX  = 3'd0,
    RegFromY  = 3'd1,
    RegToX    = 3'd2,
    RegToY    = 3'd3,
    RegBegin  = 3'd4,
    RegFinish = 3'd5
  } reg_idx_e;

endpackage

/* rtl/qts_div.sv */
// Pipelined restoring divider that retires one quotient bit per stage.
module qts_div #(
  parameter int unsigned QuotW = 31,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [31:0]      rem_i,
  input  logic [QuotW-1:0] low_i,
  input  logic [31:0]      divisor_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot_o,
  output logic [SideW-1:0] side_o
);

  logic [QuotW-1:0] vld_q;
  logic [31:0]      rem_q  [QuotW];
  logic [QuotW-1:0] word_q [QuotW];
  logic [SideW-1:0] side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [31:0]      r_in;
    logic [QuotW-1:0] w_in;
    logic [SideW-1:0] s_in;
    logic             v_in;
    logic [32:0]      trial;
    logic             take;
    logic [31:0]      rem_d;
    logic [QuotW-1:0] word_d;

    if (k == 0) begin : g_first
      assign r_in = rem_i;
      assign w_in = low_i;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign w_in = word_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign trial  = {r_in, w_in[QuotW-1]} - {1'b0, divisor_i};
    assign take   = ~trial[32];
    assign rem_d  = take ? trial[31:0] : {r_in[30:0], w_in[QuotW-1]};
    assign word_d = {w_in[QuotW-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_d;
        word_q[k] <= word_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign quot_o  = word_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

/* rtl/qts_poly.sv */
// Pipelined evaluation of the quintic blend and its derivative from the normalized time.
module qts_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic                win_i,
  input  logic [qts_pkg::SW-1:0] s_i,
  output logic                valid_o,
  output logic                win_o,
  output logic [qts_pkg::SW-1:0] h_o,
  output logic [qts_pkg::SW-1:0] g_o
);
  import qts_pkg::*;

  function automatic logic [SW-1:0] fmul(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [2*SW-1:0] p;
    p = {{SW{1'b0}}, a} * {{SW{1'b0}}, b};
    return p[2*SBits:SBits];
  endfunction

  logic [4:0]    vld_q;
  logic [4:0]    win_q;
  logic [SW-1:0] s1_q, s2a_q, s2b_q, s3b_q, s1c_q, s1d_q, s2c_q, s3c_q, s4c_q;
  logic [SW-1:0] s2d_q, s3d_q, s4d_q, s5d_q, h_q, g_q;
  logic signed [37:0] h_raw, g_raw;
  logic [SW-1:0] h_d, g_d;

  always_comb begin
    h_raw = 38'sd10 * $signed({7'b0, s3d_q}) - 38'sd15 * $signed({7'b0, s4d_q})
          + 38'sd6 * $signed({7'b0, s5d_q});
    g_raw = 38'sd30 * $signed({7'b0, s2d_q}) - 38'sd60 * $signed({7'b0, s3d_q})
          + 38'sd30 * $signed({7'b0, s4d_q});
    if (h_raw < 0) begin
      h_d = '0;
    end else if (h_raw > (38'sd1 <<< SBits)) begin
      h_d = SW'(1) << SBits;
    end else begin
      h_d = h_raw[SW-1:0];
    end
    if (g_raw < 0) begin
      g_d = '0;
    end else begin
      g_d = g_raw[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      win_q <= {win_q[3:0], win_i};
      s1_q  <= s_i;
      s2a_q <= fmul(s_i, s_i);
      s1c_q <= s1_q;
      s2b_q <= s2a_q;
      s3b_q <= fmul(s2a_q, s1_q);
      s1d_q <= s1c_q;
      s2c_q <= s2b_q;
      s3c_q <= s3b_q;
      s4c_q <= fmul(s3b_q, s1c_q);
      s2d_q <= s2c_q;
      s3d_q <= s3c_q;
      s4d_q <= s4c_q;
      s5d_q <= fmul(s4c_q, s1d_q);
      h_q   <= h_d;
      g_q   <= g_d;
    end
  end

  assign valid_o = vld_q[4];
  assign win_o   = win_q[4];
  assign h_o     = h_q;
  assign g_o     = g_q;

endmodule

/* rtl/quintic_trajectory_sampler.sv */
// Top level of the two-axis minimum-jerk quintic trajectory sampler.
//
// Configuration is written through cfg_we_i, cfg_addr_i and cfg_wdata_i: start and
// end positions of both axes and the start and finish times of the move. The user
// must write it only while no transaction is in flight; the block does not enforce
// this. Each input transaction carries one sample time and produces exactly one
// output transaction with the window flag, the two positions and the two
// velocities, in input order. An accepted input passes the window stage, the time
// divider, the blend pipeline, the scaling and rounding stages, the velocity
// dividers and the output register. One transaction is accepted per cycle while
// the receiver does not stall; most of the latency comes from the two bit-per-stage
// divider pipelines (31 stages for the normalized time, 32 for the velocities). All
// stages advance together; when the receiver stalls with a result held in the
// output register, the whole pipeline holds and in_ready_o drops, so no transaction
// is lost or repeated. Reset clears all configuration registers and all valid bits.
module quintic_trajectory_sampler #(
  parameter int unsigned FracBits = qts_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qts_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [qts_pkg::DataW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  sample_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         in_window_o,
  output logic signed [31:0]           pos_x_o,
  output logic signed [31:0]           pos_y_o,
  output logic signed [31:0]           vel_x_o,
  output logic signed [31:0]           vel_y_o
);
  import qts_pkg::*;

  localparam int unsigned DvdW = MagW + FracBits;
  localparam int unsigned HiW  = DvdW - 32;

  logic [31:0] from_x_q, from_y_q, to_x_q, to_y_q, begin_q, finish_q;
  logic        adv;
  logic [31:0] dur;
  logic        out_valid_q;

  assign dur        = finish_q - begin_q;
  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_x_q <= '0;
      from_y_q <= '0;
      to_x_q   <= '0;
      to_y_q   <= '0;
      begin_q  <= '0;
      finish_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegFromX:  from_x_q <= cfg_wdata_i;
        RegFromY:  from_y_q <= cfg_wdata_i;
        RegToX:    to_x_q   <= cfg_wdata_i;
        RegToY:    to_y_q   <= cfg_wdata_i;
        RegBegin:  begin_q  <= cfg_wdata_i;
        RegFinish: finish_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window check and relative time.
  logic        a_vld_q, a_win_q;
  logic [31:0] a_rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_win_q <= (finish_q > begin_q) && (sample_time_i >= begin_q)
              && (sample_time_i <= finish_q);
      a_rel_q <= sample_time_i - begin_q;
    end
  end

  logic          sd_vld, sd_win;
  logic [SW-1:0] sd_s;

  qts_div #(.QuotW(SW), .SideW(1)) u_div_s (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (a_vld_q),
    .rem_i     ({1'b0, a_rel_q[31:1]}),
    .low_i     ({a_rel_q[0], {SBits{1'b0}}}),
    .divisor_i (dur),
    .side_i    (a_win_q),
    .valid_o   (sd_vld),
    .quot_o    (sd_s),
    .side_o    (sd_win)
  );

  logic          p_vld, p_win;
  logic [SW-1:0] p_h, p_g;

  qts_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sd_vld),
    .win_i   (sd_win),
    .s_i     (sd_s),
    .valid_o (p_vld),
    .win_o   (p_win),
    .h_o     (p_h),
    .g_o     (p_g)
  );

  // Scale the blend terms by the per-axis travel.
  logic signed [32:0] dx, dy;
  logic signed [63:0] hx_q, gx_q, hy_q, gy_q;
  logic               m_vld_q, m_win_q;

  assign dx = $signed({to_x_q[31], to_x_q}) - $signed({from_x_q[31], from_x_q});
  assign dy = $signed({to_y_q[31], to_y_q}) - $signed({from_y_q[31], from_y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= p_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_win_q <= p_win;
      hx_q    <= 64'(dx) * $signed({33'b0, p_h});
      gx_q    <= 64'(dx) * $signed({33'b0, p_g});
      hy_q    <= 64'(dy) * $signed({33'b0, p_h});
      gy_q    <= 64'(dy) * $signed({33'b0, p_g});
    end
  end

  // Rounding of positions and velocity numerators.
  logic signed [63:0] rhx, rgx, rhy, rgy;
  logic [31:0]        r_posx_q, r_posy_q;
  logic signed [MagW-1:0] r_mx_q, r_my_q;
  logic               r_vld_q, r_win_q;

  assign rhx = hx_q + (64'sd1 <<< (SBits - 1));
  assign rgx = gx_q + (64'sd1 <<< (SBits - 1));
  assign rhy = hy_q + (64'sd1 <<< (SBits - 1));
  assign rgy = gy_q + (64'sd1 <<< (SBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_win_q  <= m_win_q;
      r_posx_q <= from_x_q + rhx[SBits+31:SBits];
      r_posy_q <= from_y_q + rhy[SBits+31:SBits];
      r_mx_q   <= rgx[SBits+MagW-1:SBits];
      r_my_q   <= rgy[SBits+MagW-1:SBits];
    end
  end

  // Velocity dividend setup and overflow detection.
  logic            nx, ny, ox, oy;
  logic [MagW-1:0] magx, magy;
  logic [DvdW-1:0] dvx, dvy;
  logic [31:0]     hix, hiy;

  assign nx   = r_mx_q[MagW-1];
  assign ny   = r_my_q[MagW-1];
  assign magx = nx ? MagW'(-r_mx_q) : MagW'(r_mx_q);
  assign magy = ny ? MagW'(-r_my_q) : MagW'(r_my_q);
  assign dvx  = {magx, {FracBits{1'b0}}};
  assign dvy  = {magy, {FracBits{1'b0}}};
  assign hix  = {{(32-HiW){1'b0}}, dvx[DvdW-1:32]};
  assign hiy  = {{(32-HiW){1'b0}}, dvy[DvdW-1:32]};
  assign ox   = hix >= dur;
  assign oy   = hiy >= dur;

  logic        vx_vld, vy_vld;
  logic [31:0] qx, qy;
  logic [34:0] sx;
  logic [33:0] sy;

  qts_div #(.QuotW(32), .SideW(35)) u_div_vx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (r_vld_q),
    .rem_i     (hix),
    .low_i     (dvx[31:0]),
    .divisor_i (dur),
    .side_i    ({r_win_q, nx, ox, r_posx_q}),
    .valid_o   (vx_vld),
    .quot_o    (qx),
    .side_o    (sx)
  );

  qts_div #(.QuotW(32), .SideW(34)) u_div_vy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (r_vld_q),
    .rem_i     (hiy),
    .low_i     (dvy[31:0]),
    .divisor_i (dur),
    .side_i    ({ny, oy, r_posy_q}),
    .valid_o   (vy_vld),
    .quot_o    (qy),
    .side_o    (sy)
  );

  function automatic logic [31:0] vsat(input logic [31:0] q, input logic neg, input logic ovf);
    logic [31:0] v;
    if (neg) begin
      v = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q);
    end else begin
      v = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    end
    return v;
  endfunction

  logic        win_f;
  logic [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic        in_window_q;

  assign win_f = sx[34];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vx_vld & vy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_window_q <= win_f;
      pos_x_q     <= win_f ? sx[31:0] : 32'd0;
      pos_y_q     <= win_f ? sy[31:0] : 32'd0;
      vel_x_q     <= win_f ? vsat(qx, sx[33], sx[32]) : 32'd0;
      vel_y_q     <= win_f ? vsat(qy, sy[33], sy[32]) : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_window_o = in_window_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;

endmodule

/* rtl/qts_checker.sv */
// Port-level assertions for the quintic trajectory sampler and their bind.
module qts_assert (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         in_window_o,
  input logic signed [31:0]           pos_x_o,
  input logic signed [31:0]           pos_y_o,
  input logic signed [31:0]           vel_x_o,
  input logic signed [31:0]           vel_y_o
);

  // A stalled output transaction stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // The input side is blocked only while a result waits on a stalled receiver.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  // Results outside the window carry zero positions.
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_window_o |-> pos_x_o == 0 && pos_y_o == 0)
    else $error("nonzero position outside the window");

  // Results outside the window carry zero velocities.
  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_window_o |-> vel_x_o == 0 && vel_y_o == 0)
    else $error("nonzero velocity outside the window");

endmodule

bind quintic_trajectory_sampler qts_assert u_qts_assert (.*);

/* verif/qts_checker.sv */
// Checker for the quintic trajectory sampler: mirrors configuration, predicts and compares results.
module qts_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qts_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [qts_pkg::DataW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [31:0]                  sample_time_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         in_window_i,
  input  logic signed [31:0]           pos_x_i,
  input  logic signed [31:0]           pos_y_i,
  input  logic signed [31:0]           vel_x_i,
  input  logic signed [31:0]           vel_y_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qts_pkg::*;

  typedef struct packed {
    logic               in_window;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } sample_t;

  logic signed [31:0] start_pos [2];
  logic signed [31:0] end_pos [2];
  logic [31:0]        t_begin;
  logic [31:0]        t_finish;
  sample_t            expected_samples [$];

  function automatic sample_t trajectory_at(logic [31:0] t);
    sample_t            r;
    longint unsigned    dur, rel, s, s2, s3, s4, s5;
    longint             h, g;
    logic signed [127:0] delta, hw, gw, dw, pos, m, mag, q, vel;
    logic               neg;
    r = '0;
    if (t_finish <= t_begin || t < t_begin || t > t_finish) return r;
    dur = longint'(t_finish) - longint'(t_begin);
    rel = longint'(t) - longint'(t_begin);
    s   = (rel << SBits) / dur;
    s2  = (s * s) >> SBits;
    s3  = (s2 * s) >> SBits;
    s4  = (s3 * s) >> SBits;
    s5  = (s4 * s) >> SBits;
    h = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
    if (h < 0) h = 0;
    if (h > (longint'(1) << SBits)) h = longint'(1) << SBits;
    g = 30 * longint'(s2) - 60 * longint'(s3) + 30 * longint'(s4);
    if (g < 0) g = 0;
    hw = h;
    gw = g;
    dw = dur;
    r.in_window = 1'b1;
    for (int i = 0; i < 2; i++) begin
      delta = 128'(signed'(end_pos[i])) - 128'(signed'(start_pos[i]));
      pos = 128'(signed'(start_pos[i])) + ((delta * hw + (128'sd1 <<< (SBits - 1))) >>> SBits);
      m = (delta * gw + (128'sd1 <<< (SBits - 1))) >>> SBits;
      neg = m < 0;
      mag = neg ? -m : m;
      q = (mag <<< FracBitsDef) / dw;
      if (neg) begin
        if (q > 128'sh80000000) q = 128'sh80000000;
        vel = -q;
      end else begin
        if (q > 128'sh7FFFFFFF) q = 128'sh7FFFFFFF;
        vel = q;
      end
      if (i == 0) begin
        r.pos_x = pos[31:0];
        r.vel_x = vel[31:0];
      end else begin
        r.pos_y = pos[31:0];
        r.vel_y = vel[31:0];
      end
    end
    return r;
  endfunction

  assign pending_o = expected_samples.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t e;
    if (!rst_ni) begin
      start_pos = '{0, 0};
      end_pos   = '{0, 0};
      t_begin   = '0;
      t_finish  = '0;
      errors_o  = 0;
      expected_samples.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result transaction, pos_x %h", $time, pos_x_i);
          errors_o++;
        end else begin
          e = expected_samples.pop_front();
          if (e.in_window !== in_window_i) begin
            $display("%0t: in_window expected %b actual %b", $time, e.in_window, in_window_i);
            errors_o++;
          end
          if (e.pos_x !== pos_x_i) begin
            $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, pos_x_i);
            errors_o++;
          end
          if (e.pos_y !== pos_y_i) begin
            $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, pos_y_i);
            errors_o++;
          end
          if (e.vel_x !== vel_x_i) begin
            $display("%0t: vel_x expected %h actual %h", $time, e.vel_x, vel_x_i);
            errors_o++;
          end
          if (e.vel_y !== vel_y_i) begin
            $display("%0t: vel_y expected %h actual %h", $time, e.vel_y, vel_y_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_samples = {expected_samples, trajectory_at(sample_time_i)};
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegFromX:  start_pos[0] = cfg_wdata_i;
          RegFromY:  start_pos[1] = cfg_wdata_i;
          RegToX:    end_pos[0]   = cfg_wdata_i;
          RegToY:    end_pos[1]   = cfg_wdata_i;
          RegBegin:  t_begin      = cfg_wdata_i;
          RegFinish: t_finish     = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the quintic trajectory sampler testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qts_pkg::*;

  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;
  localparam int unsigned         Latency   = 72;
  localparam longint              MaxCycles = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [DataW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        sample_time_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               in_window_o;
  logic signed [31:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o;
  int                 errors, pending;
  bit                 busy_mode;
  longint             cycles;

  quintic_trajectory_sampler i_dut (.*);

  qts_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .sample_time_i,
    .out_valid_i(out_valid_o), .out_ready_i, .in_window_i(in_window_o),
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .vel_x_i(vel_x_o), .vel_y_i(vel_y_o),
    .errors_o(errors), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk_i) begin
    logic rdy;
    rdy = ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 10);
    if ($urandom_range(0, 199) == 0) rdy = 1'b0;
    out_ready_i <= busy_mode || rdy;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] fx, logic [31:0] fy, logic [31:0] tx,
                           logic [31:0] ty, logic [31:0] b, logic [31:0] f);
    write_reg(RegFromX, fx);
    write_reg(RegFromY, fy);
    write_reg(RegToX, tx);
    write_reg(RegToY, ty);
    write_reg(RegBegin, b);
    write_reg(RegFinish, f);
    write_reg(RegUnused, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(logic [31:0] t);
    int g;
    in_valid_i    <= 1'b1;
    sample_time_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic run_phase(int n);
    logic [31:0] b, f, t;
    b = i_checker.t_begin;
    f = i_checker.t_finish;
    send(b);
    send(f);
    send(b - 1);
    send(f + 1);
    send(b + ((f - b) >> 1));
    send(32'h0);
    send(32'hFFFFFFFF);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 80 && f > b) t = b + $urandom_range(0, f - b);
      else t = $urandom;
      send(t);
    end
    drain();
  endtask

  initial begin
    logic [31:0] b, d;
    busy_mode = 1'b0;
    cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(10);
    configure(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1);
    run_phase(10);
    configure(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF);
    run_phase(120);
    configure(32'h00010000, 32'hFFFF0000, 32'h00050000, 32'h00020000, 32'h00020000, 32'h00020000);
    run_phase(20);
    configure(32'h00010000, 32'hFFFF0000, 32'h00050000, 32'h00020000, 32'h00030000, 32'h00020000);
    run_phase(20);
    configure(32'h0, 32'h0, 32'h00640000, 32'hFF9C0000, 32'hFFFF0000, 32'hFFFFFFFF);
    run_phase(60);
    for (int p = 0; p < 12; p++) begin
      busy_mode = (p % 4 == 3);
      case ($urandom_range(0, 2))
        0: d = $urandom_range(1, 16);
        1: d = $urandom_range(17, 32'h00100000);
        default: d = $urandom_range(32'h00100001, 32'hFFFFFFFF);
      endcase
      b = $urandom_range(0, 32'hFFFFFFFF - d);
      configure($urandom, $urandom, $urandom, $urandom, b, b + d);
      run_phase(100);
    end
    busy_mode = 1'b0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
